// ----- hdl/vsfc_pkg.sv -----
// Shared types and constants for the ventilation status frame checker.
// No dependencies; imported by vsfc_frame_check and the top level.
`default_nettype none

package vsfc_pkg;

    localparam logic [7:0] FRAME_HEADER  = 8'hAA;
    localparam logic [7:0] FRAME_FOOTER  = 8'hF5;
    localparam logic [7:0] HOST_ID_VALUE = 8'h02;
    localparam logic [7:0] TEMP_MASK     = 8'h7F;
    localparam logic [3:0] MIN_FRAME_LEN = 4'd10;
    localparam logic [3:0] COUNT_MAX     = 4'd15;

    // Frame byte positions
    localparam logic [3:0] POS_HEADER   = 4'd0;
    localparam logic [3:0] POS_DEVICE   = 4'd1;
    localparam logic [3:0] POS_HOST     = 4'd2;
    localparam logic [3:0] POS_SWITCH   = 4'd3;
    localparam logic [3:0] POS_SPEED    = 4'd4;
    localparam logic [3:0] POS_TEMP     = 4'd6;
    localparam logic [3:0] POS_SUM_LAST = 4'd8;
    localparam logic [3:0] POS_CHECKSUM = 4'd9;

    // Register indexes
    localparam logic REG_DEVICE_ADDRESS = 1'b0;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_FRAMING  = 3'd1,
        ERR_DEVICE   = 3'd2,
        ERR_HOST     = 3'd3,
        ERR_CHECKSUM = 3'd4,
        ERR_SHORT    = 3'd5
    } err_code_t;

    typedef struct packed {
        logic              frame_ok;
        err_code_t         error_code;
        logic [7:0]        switch_state;
        logic [7:0]        fan_speed;
        logic signed [7:0] temperature;
    } frame_result_t;

endpackage

`default_nettype wire

// ----- hdl/vsfc_frame_check.sv -----
// Per-frame state and checks of the status frame checker.
// Depends on vsfc_pkg for constants, error codes and the result struct.
`default_nettype none

module vsfc_frame_check (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   byte_accept,
    input  wire logic [7:0]             rx_byte,
    input  wire logic                   frame_end,
    input  wire logic [7:0]             device_address,
    output vsfc_pkg::frame_result_t     result
);
    import vsfc_pkg::*;

    logic [3:0] byte_count_reg,    byte_count_next;
    logic [7:0] running_sum_reg,   running_sum_next;
    logic       header_bad_reg,    header_bad_next;
    logic       device_bad_reg,    device_bad_next;
    logic       host_bad_reg,      host_bad_next;
    logic [7:0] checksum_byte_reg, checksum_byte_next;
    logic [7:0] switch_byte_reg,   switch_byte_next;
    logic [7:0] speed_byte_reg,    speed_byte_next;
    logic [6:0] temp_byte_reg,     temp_byte_next;

    err_code_t  code;

    // Capture fields and update flags for the current byte position
    always_comb begin
        byte_count_next    = byte_count_reg;
        running_sum_next   = running_sum_reg;
        header_bad_next    = header_bad_reg;
        device_bad_next    = device_bad_reg;
        host_bad_next      = host_bad_reg;
        checksum_byte_next = checksum_byte_reg;
        switch_byte_next   = switch_byte_reg;
        speed_byte_next    = speed_byte_reg;
        temp_byte_next     = temp_byte_reg;

        if (byte_count_reg == POS_HEADER)   header_bad_next    = (rx_byte != FRAME_HEADER);
        if (byte_count_reg == POS_DEVICE)   device_bad_next    = (rx_byte != device_address);
        if (byte_count_reg == POS_HOST)     host_bad_next      = (rx_byte != HOST_ID_VALUE);
        if (byte_count_reg == POS_SWITCH)   switch_byte_next   = rx_byte;
        if (byte_count_reg == POS_SPEED)    speed_byte_next    = rx_byte;
        if (byte_count_reg == POS_TEMP)     temp_byte_next     = rx_byte[6:0] & TEMP_MASK[6:0];
        if (byte_count_reg == POS_CHECKSUM) checksum_byte_next = rx_byte;
        if (byte_count_reg >= POS_DEVICE && byte_count_reg <= POS_SUM_LAST) begin
            running_sum_next = running_sum_reg + rx_byte;
        end
        if (byte_count_reg != COUNT_MAX) byte_count_next = byte_count_reg + 4'd1;
    end

    // Pick the first failing check, using this byte's updates
    always_comb begin
        priority if ({1'b0, byte_count_reg} + 5'd1 < {1'b0, MIN_FRAME_LEN}) begin
            code = ERR_SHORT;
        end else if (header_bad_next || rx_byte != FRAME_FOOTER) begin
            code = ERR_FRAMING;
        end else if (device_bad_next) begin
            code = ERR_DEVICE;
        end else if (host_bad_next) begin
            code = ERR_HOST;
        end else if (running_sum_next != checksum_byte_next) begin
            code = ERR_CHECKSUM;
        end else begin
            code = ERR_NONE;
        end
    end

    // Build the result; data fields read zero on a failed frame
    always_comb begin
        result.frame_ok     = (code == ERR_NONE);
        result.error_code   = code;
        result.switch_state = 8'd0;
        result.fan_speed    = 8'd0;
        result.temperature  = 8'sd0;
        if (code == ERR_NONE) begin
            result.switch_state = switch_byte_next;
            result.fan_speed    = speed_byte_next;
            result.temperature  = signed'(8'd0 - {1'b0, temp_byte_next});
        end
    end

    // Advance frame state on each transfer; clear it at frame end
    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_accept && frame_end)) begin
            byte_count_reg    <= '0;
            running_sum_reg   <= '0;
            header_bad_reg    <= 1'b0;
            device_bad_reg    <= 1'b0;
            host_bad_reg      <= 1'b0;
            checksum_byte_reg <= '0;
            switch_byte_reg   <= '0;
            speed_byte_reg    <= '0;
            temp_byte_reg     <= '0;
        end else if (byte_accept) begin
            byte_count_reg    <= byte_count_next;
            running_sum_reg   <= running_sum_next;
            header_bad_reg    <= header_bad_next;
            device_bad_reg    <= device_bad_next;
            host_bad_reg      <= host_bad_next;
            checksum_byte_reg <= checksum_byte_next;
            switch_byte_reg   <= switch_byte_next;
            speed_byte_reg    <= speed_byte_next;
            temp_byte_reg     <= temp_byte_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/vent_status_frame_checker_core.sv -----
// Top level of the ventilation status frame checker: stream ports, APB
// register, output register. Depends on vsfc_pkg and vsfc_frame_check.
//
// Usage:
//   Frame bytes enter on the s_ stream, one byte per transfer, with s_tlast
//   on the last byte of each frame. Bytes that are not the last give no
//   result. The last byte of a frame gives one result on the m_ stream,
//   registered, valid in the cycle after that byte's transfer.
//   Throughput is one byte per cycle while s_tready is high; the per-byte
//   compare, the add into the running sum and the check priority all sit in
//   one stage ahead of the result register.
//   s_tready stays high while the result register is empty or being taken,
//   so bytes keep flowing as long as the receiver keeps up. If the receiver
//   stalls with a result held, s_tready drops and input holds until
//   m_tready returns.
//   Reset (aresetn low, synchronous) clears the frame state, empties the
//   result register and sets device_address to zero.
//   device_address lives at byte address 0 of the APB port; write it only
//   while no frame is in flight. pready is always high.
`default_nettype none

module vent_status_frame_checker_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  wire logic        s_tlast,   // frame_end
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [0] frame_ok, [3:1] error_code,
                                        // [11:4] switch_state, [19:12] fan_speed,
                                        // [27:20] temperature, [31:28] zero
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import vsfc_pkg::*;

    logic          device_address_sel;
    logic [7:0]    dev_addr_reg;
    logic          m_valid_reg;
    frame_result_t m_result_reg;
    frame_result_t result;
    logic          byte_accept;
    logic          cfg_write;

    assign byte_accept = s_tvalid && s_tready;
    assign s_tready    = !m_valid_reg || m_tready;
    assign pready      = 1'b1;
    assign cfg_write   = psel && penable && pwrite && (paddr[2] == REG_DEVICE_ADDRESS);
    assign device_address_sel = (paddr[2] == REG_DEVICE_ADDRESS);

    vsfc_frame_check u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .byte_accept    (byte_accept),
        .rx_byte        (s_tdata),
        .frame_end      (s_tlast),
        .device_address (dev_addr_reg),
        .result         (result)
    );

    // Hold the device address register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= '0;
        end else if (cfg_write) begin
            dev_addr_reg <= pwdata[7:0];
        end
    end

    // Read back the register at addresses 0 to 3; addresses 4 to 7 read zero
    assign prdata = device_address_sel ? {24'd0, dev_addr_reg} : 32'd0;

    // Load the result on the frame's last transfer; drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (byte_accept && s_tlast) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_accept && s_tlast) begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0,
                       m_result_reg.temperature,
                       m_result_reg.fan_speed,
                       m_result_reg.switch_state,
                       m_result_reg.error_code,
                       m_result_reg.frame_ok};

endmodule

`default_nettype wire

// ----- tb/sv/tb_vent_status_frame_checker_core.sv -----
// Self-checking bench for vent_status_frame_checker_core: streams status frames
// in, predicts each frame result and compares it against the result stream.
// Depends on vsfc_pkg and the checker RTL.
`default_nettype none

module tb_vent_status_frame_checker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import vsfc_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          LONG_HOLD      = 400;
    localparam int          PHASE_BYTES    = 180;
    localparam logic [2:0]  ADDR_DEVICE    = 3'(4 * REG_DEVICE_ADDRESS);
    localparam logic [2:0]  ADDR_UNUSED    = 3'd4;

    // Ways a generated frame can be broken on purpose
    typedef enum int {
        FLT_NONE, FLT_HEADER, FLT_FOOTER, FLT_DEVICE, FLT_HOST, FLT_CHECKSUM
    } frame_fault_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } rx_byte_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    vent_status_frame_checker_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Bytes waiting to be sent and frame results waiting to arrive
    rx_byte_t      pending_bytes[$];
    frame_result_t expected_results[$];

    int mismatches    = 0;
    int bytes_sent    = 0;
    int results_seen  = 0;
    int code_hits[6]  = '{default: 0};
    int hold_token    = 0;

    // Frame tracker state, mirrors the block's own
    logic [7:0] dev_addr_model = 8'h00;
    logic [3:0] frm_pos   = 4'd0;
    logic [7:0] frm_sum   = 8'h00;
    logic       hdr_bad   = 1'b0;
    logic       addr_bad  = 1'b0;
    logic       host_bad  = 1'b0;
    logic [7:0] csum_cap  = 8'h00;
    logic [7:0] sw_cap    = 8'h00;
    logic [7:0] spd_cap   = 8'h00;
    logic [6:0] tmp_cap   = 7'h00;

    // Advance the frame tracker by one byte; queue a result on the last byte
    function automatic void track_frame_byte(input logic [7:0] b, input logic last);
        logic [3:0]    pos;
        frame_result_t res;
        pos = frm_pos;
        if (pos == POS_HEADER)   hdr_bad  = (b != FRAME_HEADER);
        if (pos == POS_DEVICE)   addr_bad = (b != dev_addr_model);
        if (pos == POS_HOST)     host_bad = (b != HOST_ID_VALUE);
        if (pos == POS_SWITCH)   sw_cap   = b;
        if (pos == POS_SPEED)    spd_cap  = b;
        if (pos == POS_TEMP)     tmp_cap  = 7'(b & TEMP_MASK);
        if (pos == POS_CHECKSUM) csum_cap = b;
        if (pos >= POS_DEVICE && pos <= POS_SUM_LAST) frm_sum = frm_sum + b;
        if (frm_pos != COUNT_MAX) frm_pos = frm_pos + 4'd1;
        if (!last) return;

        // Short frame outranks every other check
        if (({1'b0, pos} + 5'd1) < {1'b0, MIN_FRAME_LEN}) res.error_code = ERR_SHORT;
        else if (hdr_bad || b != FRAME_FOOTER)           res.error_code = ERR_FRAMING;
        else if (addr_bad)                               res.error_code = ERR_DEVICE;
        else if (host_bad)                               res.error_code = ERR_HOST;
        else if (frm_sum != csum_cap)                    res.error_code = ERR_CHECKSUM;
        else                                             res.error_code = ERR_NONE;
        res.frame_ok = (res.error_code == ERR_NONE);
        if (res.frame_ok) begin
            res.switch_state = sw_cap;
            res.fan_speed    = spd_cap;
            res.temperature  = 8'h00 - {1'b0, tmp_cap};
        end else begin
            res.switch_state = 8'h00;
            res.fan_speed    = 8'h00;
            res.temperature  = 8'h00;
        end
        expected_results.push_back(res);

        frm_pos  = 4'd0;
        frm_sum  = 8'h00;
        hdr_bad  = 1'b0;
        addr_bad = 1'b0;
        host_bad = 1'b0;
        csum_cap = 8'h00;
        sw_cap   = 8'h00;
        spd_cap  = 8'h00;
        tmp_cap  = 7'h00;
    endfunction

    // Build a frame of len bytes (1..20) and queue it; len below ten gives a short frame
    task automatic queue_frame(input int len, input frame_fault_t fault,
                               input logic [7:0] sw, input logic [7:0] spd,
                               input logic [7:0] tmp);
        logic [7:0] fb [20];
        logic [7:0] partial;
        foreach (fb[i]) fb[i] = 8'($urandom);
        fb[0] = FRAME_HEADER;
        fb[1] = dev_addr_model;
        fb[2] = HOST_ID_VALUE;
        fb[3] = sw;
        fb[4] = spd;
        fb[6] = tmp;
        partial = 8'h00;
        for (int i = 1; i <= 7; i++) partial = partial + fb[i];
        if (len == 10) begin
            // checksum byte doubles as footer, so steer byte 8 to make them agree
            fb[8] = FRAME_FOOTER - partial;
            fb[9] = FRAME_FOOTER;
        end else if (len > 10) begin
            fb[9]       = partial + fb[8];
            fb[len - 1] = FRAME_FOOTER;
        end
        case (fault)
            FLT_HEADER:   fb[0]       ^= 8'($urandom_range(1, 255));
            FLT_FOOTER:   fb[len - 1] ^= 8'($urandom_range(1, 255));
            FLT_DEVICE:   fb[1]       ^= 8'($urandom_range(1, 255));
            FLT_HOST:     fb[2]       ^= 8'($urandom_range(1, 255));
            FLT_CHECKSUM: fb[9]       ^= 8'($urandom_range(1, 255));
            default: ;
        endcase
        for (int i = 0; i < len; i++) pending_bytes.push_back('{fb[i], i == len - 1});
    endtask

    // Fill one phase with a mix of good, broken, short and junk frames
    task automatic queue_random_traffic(input int n_bytes);
        int start;
        int pick;
        int len;
        start = pending_bytes.size();
        while (pending_bytes.size() - start < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20)
                                                  : $urandom_range(10, 13);
                queue_frame(len,
                            $urandom_range(0, 1) ? FLT_NONE
                                                 : frame_fault_t'($urandom_range(1, 5)),
                            8'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 75) begin
                queue_frame($urandom_range(1, 9), FLT_NONE,
                            8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                len = $urandom_range(1, 16);
                for (int i = 0; i < len; i++)
                    pending_bytes.push_back('{8'($urandom), i == len - 1});
            end
        end
    endtask

    // One APB transfer: setup cycle, then access until pready
    task automatic apb_access(input logic wr, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write the device address, then read it back
    task automatic set_device_address(input logic [7:0] addr);
        logic [31:0] rd;
        apb_access(1'b1, ADDR_DEVICE, {24'h0, addr}, rd);
        dev_addr_model = addr;
        apb_access(1'b0, ADDR_DEVICE, 32'h0, rd);
        if (rd !== {24'h0, dev_addr_model}) begin
            $error("device_address readback: expected %0h, got %0h", dev_addr_model, rd);
            mismatches++;
        end
    endtask

    // Hold until every byte is taken and every result is in
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Sender: bursts of random length with random gaps between them
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_frame_byte(s_tdata, s_tlast);
                pending_bytes.delete(0);
                bytes_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transfer until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_bytes.size() == 0) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_bytes[0].data;
                s_tlast  <= pending_bytes[0].last;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
    end

    // Receiver: runs of ready, stall or coin-flip, plus a long hold-off on request
    int hold_seen  = 0;
    int hold_left  = 0;
    int ready_run  = 0;
    int ready_mode = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (ready_run == 0) begin
                ready_run  = $urandom_range(1, 20);
                ready_mode = $urandom_range(0, 3);
            end
            ready_run--;
            case (ready_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'b0;
                default: m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result transfer with the oldest pending frame result
    always @(posedge aclk) begin
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no frame pending: tdata %0h", m_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("frame_ok",     8'(want.frame_ok),     8'(m_tdata[0]));
                check_field("error_code",   8'(want.error_code),   8'(m_tdata[3:1]));
                check_field("switch_state", want.switch_state,     m_tdata[11:4]);
                check_field("fan_speed",    want.fan_speed,        m_tdata[19:12]);
                check_field("temperature",  want.temperature,      m_tdata[27:20]);
                check_field("pad",          8'h00,                 8'(m_tdata[31:28]));
                code_hits[want.error_code]++;
                results_seen++;
            end
        end
    end

    // Watchdog: end the run when work is pending but nothing moves for too long
    int stuck_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((pending_bytes.size() != 0 || expected_results.size() != 0)
                && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
                stuck_cycles++;
            else
                stuck_cycles = 0;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed frames, then randomized phases
    initial begin
        logic [31:0] rd;
        logic [7:0]  addr_plan [5];
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A write to an address with no register must leave device_address alone
        apb_access(1'b1, ADDR_UNUSED, 32'h0000_005A, rd);
        apb_access(1'b0, ADDR_DEVICE, 32'h0, rd);
        if (rd !== {24'h0, dev_addr_model}) begin
            $error("device_address after unused write: expected %0h, got %0h",
                   dev_addr_model, rd);
            mismatches++;
        end

        // Directed: zero temperature with bit 7 set, a lone last byte, minimum length
        set_device_address(8'h00);
        @(negedge aclk);
        queue_frame(11, FLT_NONE, 8'hFF, 8'h00, 8'h80);
        queue_frame(1,  FLT_NONE, 8'h00, 8'h00, 8'h00);
        queue_frame(10, FLT_NONE, 8'h00, 8'hFF, 8'h7F);
        wait_drained();

        addr_plan = '{8'hFF, 8'($urandom), 8'h00, 8'($urandom), HOST_ID_VALUE};
        for (int p = 0; p < 5; p++) begin
            set_device_address(addr_plan[p]);
            @(negedge aclk);
            queue_random_traffic(PHASE_BYTES);
            // stall the receiver long enough to back up the input
            if (p == 1) hold_token++;
            wait_drained();
        end

        $display("covered %0d bytes and %0d frame results over six address settings",
                 bytes_sent, results_seen);
        $display("results by code: ok %0d framing %0d device %0d host %0d checksum %0d short %0d",
                 code_hits[ERR_NONE], code_hits[ERR_FRAMING], code_hits[ERR_DEVICE],
                 code_hits[ERR_HOST], code_hits[ERR_CHECKSUM], code_hits[ERR_SHORT]);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
